// ===== rtl/dlpt_pkg.sv =====
package dlpt_pkg;

	// counter and setting width
	localparam int unsigned CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// register indexes
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_HOLD     = 1'b1;

	// register reset values
	localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CNT_W-1:0] HOLD_RST     = 16'd3000;

	// button levels
	localparam logic LVL_PRESSED  = 1'b0;
	localparam logic LVL_RELEASED = 1'b1;

	// one tick request
	typedef struct packed {
		logic ack_change;
		logic clear_request;
		logic button_level;
	} item_t;

	// one tick result
	typedef struct packed {
		logic hold_fired;
		logic stable_pressed;
		logic state_changed;
		logic alarm_active;
	} result_t;

	// saturating increment
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
	endfunction

endpackage

// ===== rtl/debounced_long_press_toggle.sv =====
// a request is held in the input register, then in the result register, until the output takes it
// throughput: one request per cycle unless the output stalls; input and result registers advance together
// the state update of one tick is a single pass of compare and increment logic
// reset: asynchronous active low; settings return to 50 and 3000 ticks, levels to
// released, counters and flags to zero, both pipeline stages empty
module debounced_long_press_toggle (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,  // button_level, clear_request, ack_change
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [7:0]                 m_axis_tdata,  // alarm_active, state_changed, stable_pressed, hold_fired
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [dlpt_pkg::CNT_W-1:0] cfg_wdata
);
	import dlpt_pkg::*;

	logic [CNT_W-1:0] debounce_ticks_q;
	logic [CNT_W-1:0] hold_ticks_q;
	item_t            item_s1;
	logic             valid_s1;
	result_t          res_s2;
	logic             valid_s2;
	result_t          res;
	logic             advance;
	logic             en;

	// pipeline moves when the result slot is free or being taken
	assign advance = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign en = valid_s1 && advance;

	// settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RST;
			hold_ticks_q <= HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_ticks_q <= cfg_wdata;
				REG_HOLD:     hold_ticks_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_t'(s_axis_tdata[2:0]);
		end
	end

	// tick logic and state
	dlpt_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.item           (item_s1),
		.debounce_ticks (debounce_ticks_q),
		.hold_ticks     (hold_ticks_q),
		.res            (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {4'b0000, res_s2};

endmodule

// ===== rtl/dlpt_core.sv =====
module dlpt_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  dlpt_pkg::item_t               item,
	input  logic [dlpt_pkg::CNT_W-1:0]    debounce_ticks,
	input  logic [dlpt_pkg::CNT_W-1:0]    hold_ticks,
	output dlpt_pkg::result_t             res
);
	import dlpt_pkg::*;

	logic             last_sample_q;
	logic             stable_q;
	logic [CNT_W-1:0] debounce_cnt_q;
	logic             holding_q;
	logic [CNT_W-1:0] hold_cnt_q;
	logic             hold_done_q;
	logic             alarm_q;
	logic             changed_q;

	logic             stable_d;
	logic [CNT_W-1:0] debounce_cnt_d;
	logic             holding_d;
	logic [CNT_W-1:0] hold_cnt_d;
	logic             hold_done_d;
	logic             alarm_d;
	logic             changed_d;
	logic             fire;
	logic             settle;

	// next state for one tick
	always_comb begin
		hold_cnt_d = holding_q ? sat_inc(hold_cnt_q) : hold_cnt_q;
		debounce_cnt_d = (item.button_level != last_sample_q) ? '0 : sat_inc(debounce_cnt_q);
		stable_d = stable_q;
		holding_d = holding_q;
		hold_done_d = hold_done_q;
		settle = (debounce_cnt_d >= debounce_ticks) && (item.button_level != stable_q);
		if (settle) begin
			stable_d = item.button_level;
			holding_d = (item.button_level == LVL_PRESSED);
			hold_cnt_d = '0;
			hold_done_d = 1'b0;
		end
		fire = holding_d && !hold_done_d && (hold_cnt_d >= hold_ticks);
		alarm_d = alarm_q ^ fire;
		changed_d = changed_q | fire;
		if (fire) begin
			hold_done_d = 1'b1;
		end
		// clear drops an active alarm
		if (item.clear_request && alarm_d) begin
			alarm_d = 1'b0;
			changed_d = 1'b1;
		end
		// acknowledge is applied last
		if (item.ack_change) begin
			changed_d = 1'b0;
		end
	end

	// result of this tick
	always_comb begin
		res.alarm_active = alarm_d;
		res.state_changed = changed_d;
		res.stable_pressed = (stable_d == LVL_PRESSED);
		res.hold_fired = fire;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= LVL_RELEASED;
			stable_q <= LVL_RELEASED;
			debounce_cnt_q <= '0;
			holding_q <= 1'b0;
			hold_cnt_q <= '0;
			hold_done_q <= 1'b0;
			alarm_q <= 1'b0;
			changed_q <= 1'b0;
		end else if (en) begin
			last_sample_q <= item.button_level;
			stable_q <= stable_d;
			debounce_cnt_q <= debounce_cnt_d;
			holding_q <= holding_d;
			hold_cnt_q <= hold_cnt_d;
			hold_done_q <= hold_done_d;
			alarm_q <= alarm_d;
			changed_q <= changed_d;
		end
	end

	// a hold runs only while the stable level is pressed
	a_hold_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		holding_q |-> (stable_q == LVL_PRESSED))
		else $error("hold active while released");

	// a fired hold is marked done so it toggles once per press
	a_fire_once: assert property (@(posedge clk) disable iff (!arst_n)
		en && fire |=> hold_done_q && holding_q)
		else $error("hold fired without being marked done");

	// the alarm only turns on from a hold
	a_alarm_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(alarm_q) |-> $past(en && fire))
		else $error("alarm set without a long press");

	// acknowledge always leaves the changed flag low
	a_ack_wins: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.ack_change |=> !changed_q)
		else $error("changed flag set after acknowledge");

endmodule
